[hw/rtl/stt_pkg.sv]
// Shared types, constants and byte classifiers for the source text tokenizer.
// Used by stt_front, stt_queue, stt_back and source_text_tokenizer_top.
// Depends on nothing else.
package stt_pkg;

    localparam int MAX_TOKEN_LEN   = 1024;
    localparam int LINE_COUNT_BITS = 20;
    localparam int TOK_LEN_BITS    = $clog2(MAX_TOKEN_LEN);
    localparam int OUT_DATA_BITS   = ((8 + LINE_COUNT_BITS + 7) / 8) * 8;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);

    localparam logic [TOK_LEN_BITS-1:0] TOK_LEN_LIMIT = TOK_LEN_BITS'(MAX_TOKEN_LEN - 1);

    // Register word addresses.
    localparam logic REG_ALLOW_LINE_BREAKS = 1'b0;

    // Character codes.
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UE     = 8'h45;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LE     = 8'h65;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_QUOTE,
        MODE_NUMBER,
        MODE_WORD,
        MODE_OP2,
        MODE_LINECOM,
        MODE_BLOCKCOM
    } lex_mode_t;

    typedef enum logic [2:0] {
        CLS_QUOTED,
        CLS_NUMBER,
        CLS_WORD,
        CLS_OPERATOR,
        CLS_PUNCT,
        CLS_LINE_BREAK,
        CLS_END
    } tok_class_t;

    // One unit of work for the back end: a byte with its two successors,
    // or the end-of-text command.
    typedef struct packed {
        logic       is_end;
        logic [7:0] b;
        logic [7:0] n1;
        logic [7:0] n2;
    } work_t;

    typedef struct packed {
        logic [LINE_COUNT_BITS-1:0] line;
        logic [7:0]                 tbyte;
        tok_class_t                 cls;
        logic                       first;
        logic                       last;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
    endfunction

    function automatic logic word_start(input logic [7:0] c);
        return is_alpha(c) || (c == CH_UNDER) || (c == CH_SLASH) || (c == CH_BSLASH)
            || (c == CH_DOLLAR) || (c == CH_STAR);
    endfunction

    function automatic logic word_cont(input logic [7:0] c);
        return word_start(c) || is_digit(c) || (c == CH_MINUS) || (c == CH_COLON)
            || (c == CH_DOT) || (c == CH_AT);
    endfunction

    function automatic logic is_op_pair(input logic [7:0] a, input logic [7:0] c);
        logic eq_pair;
        logic dbl_pair;
        eq_pair  = (c == CH_EQ) && ((a == CH_PLUS) || (a == CH_MINUS) || (a == CH_STAR)
            || (a == CH_SLASH) || (a == CH_AMP) || (a == CH_BAR) || (a == CH_LT)
            || (a == CH_GT) || (a == CH_EQ) || (a == CH_BANG));
        dbl_pair = (c == a) && ((a == CH_PLUS) || (a == CH_MINUS) || (a == CH_AMP)
            || (a == CH_BAR));
        return eq_pair || dbl_pair;
    endfunction

endpackage

[hw/rtl/stt_front.sv]
// Front end of the tokenizer: takes source bytes, keeps the two-byte
// lookahead and turns each byte into a work item; flushes at end of text.
// Depends on stt_pkg.
module stt_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_byte,
    output logic           push,
    output stt_pkg::work_t push_item,
    input  logic           q_full
);

    logic [7:0] la0_reg, la0_next;
    logic [7:0] la1_reg, la1_next;
    logic [1:0] la_cnt_reg, la_cnt_next;
    logic       flush_reg, flush_next;
    logic       accept;
    logic [7:0] flush_n1;

    assign in_ready = !flush_reg && !q_full;
    assign accept   = in_valid && in_ready;
    assign flush_n1 = (la_cnt_reg == 2'd2) ? la1_reg : 8'd0;

    always_comb
    begin
        la0_next    = la0_reg;
        la1_next    = la1_reg;
        la_cnt_next = la_cnt_reg;
        flush_next  = flush_reg;
        push        = 1'b0;
        push_item   = '0;
        if (accept && (in_byte != 8'd0))
        begin
            if (la_cnt_reg == 2'd0)
            begin
                la0_next    = in_byte;
                la_cnt_next = 2'd1;
            end
            else if (la_cnt_reg == 2'd1)
            begin
                la1_next    = in_byte;
                la_cnt_next = 2'd2;
            end
            else
            begin
                push         = 1'b1;
                push_item.b  = la0_reg;
                push_item.n1 = la1_reg;
                push_item.n2 = in_byte;
                la0_next     = la1_reg;
                la1_next     = in_byte;
            end
        end
        else if (accept || (flush_reg && !q_full))
        begin
            // End of text: drain the held bytes one per cycle while the queue has room, then the end command.
            push = 1'b1;
            if (la_cnt_reg == 2'd0)
            begin
                push_item.is_end = 1'b1;
                flush_next       = 1'b0;
            end
            else
            begin
                push_item.b  = la0_reg;
                push_item.n1 = flush_n1;
                push_item.n2 = 8'd0;
                la0_next     = la1_reg;
                la1_next     = 8'd0;
                la_cnt_next  = la_cnt_reg - 2'd1;
                flush_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            la0_reg    <= 8'd0;
            la1_reg    <= 8'd0;
            la_cnt_reg <= 2'd0;
            flush_reg  <= 1'b0;
        end
        else
        begin
            la0_reg    <= la0_next;
            la1_reg    <= la1_next;
            la_cnt_reg <= la_cnt_next;
            flush_reg  <= flush_next;
        end
    end

    a_la_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        la_cnt_reg != 2'd3)
        else $error("lookahead count out of range");

    a_flush_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (flush_reg && (la_cnt_reg == 2'd0) && !q_full) |=> !flush_reg)
        else $error("flush did not finish after the end command");

endmodule

[hw/rtl/stt_queue.sv]
// Small register FIFO of work items between the tokenizer front and back ends.
// Depends on stt_pkg.
module stt_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  stt_pkg::work_t push_item,
    output logic           full,
    input  logic           pop,
    output stt_pkg::work_t pop_item,
    output logic           empty
);

    stt_pkg::work_t                       mem_reg [stt_pkg::QUEUE_DEPTH];
    logic [stt_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [stt_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [stt_pkg::QUEUE_PTR_BITS:0]     count_reg, count_next;
    logic                                 do_push;
    logic                                 do_pop;

    assign full     = (count_reg == (stt_pkg::QUEUE_PTR_BITS+1)'(stt_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hw/rtl/stt_back.sv]
// Back end of the tokenizer: runs the lexer state machine on each work item
// and queues up to two results in a two-slot output buffer.
// Depends on stt_pkg.
module stt_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                allow_line_breaks,
    input  logic                                q_empty,
    input  stt_pkg::work_t                      item,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output stt_pkg::result_t                    out_res
);

    stt_pkg::lex_mode_t                     mode_reg, mode_next;
    logic [stt_pkg::TOK_LEN_BITS-1:0]       len_reg, len_next;
    logic                                   nl_reg, nl_next;
    logic [stt_pkg::LINE_COUNT_BITS-1:0]    lc_reg, lc_next;
    logic [1:0]                             exp_reg, exp_next;
    logic                                   skip_reg, skip_next;

    stt_pkg::result_t                       q0_reg, q0_next;
    stt_pkg::result_t                       q1_reg, q1_next;
    logic [1:0]                             occ_reg, occ_next;

    logic                                   out_take;
    logic                                   marker;
    logic                                   put_v;
    stt_pkg::result_t                       put_r;
    logic                                   tok_v;
    logic [7:0]                             tok_b;
    stt_pkg::tok_class_t                    tok_c;
    logic                                   tok_l;
    logic [stt_pkg::TOK_LEN_BITS-1:0]       len_base;
    logic                                   tres_v;
    stt_pkg::result_t                       tres;
    logic                                   num_v;
    logic [1:0]                             exp_in;
    logic                                   num_cont;
    logic [1:0]                             exp_out;
    logic                                   cnt_line;
    logic                                   cont;
    logic                                   second_v;
    stt_pkg::result_t                       second;
    stt_pkg::result_t                       mark_r;
    stt_pkg::result_t                       r0;
    stt_pkg::result_t                       r1;
    logic [1:0]                             n_res;

    assign out_take  = out_valid && out_ready;
    assign out_valid = (occ_reg != 2'd0);
    assign out_res   = q0_reg;
    // A work item may produce two results, so it is taken only once the
    // buffer is empty after this cycle's output transfer.
    assign pop = !q_empty && ((occ_reg == 2'd0) || ((occ_reg == 2'd1) && out_ready));

    always_comb
    begin
        mode_next = mode_reg;
        len_next  = len_reg;
        nl_next   = nl_reg;
        exp_next  = exp_reg;
        skip_next = skip_reg;
        marker    = 1'b0;
        put_v     = 1'b0;
        put_r     = '0;
        tok_v     = 1'b0;
        tok_b     = item.b;
        tok_c     = stt_pkg::CLS_QUOTED;
        tok_l     = 1'b0;
        len_base  = len_reg;
        num_v     = 1'b0;
        exp_in    = exp_reg;
        cnt_line  = 1'b0;
        cont      = 1'b0;
        num_cont  = 1'b0;
        exp_out   = exp_reg;
        tres_v    = 1'b0;
        tres      = '0;
        if (pop)
        begin
            if (item.is_end)
            begin
                put_v       = 1'b1;
                put_r.cls   = stt_pkg::CLS_END;
                put_r.first = 1'b1;
                put_r.last  = 1'b1;
                mode_next   = stt_pkg::MODE_IDLE;
                len_next    = '0;
                nl_next     = 1'b0;
                exp_next    = 2'd0;
                skip_next   = 1'b0;
            end
            else if (skip_reg)
            begin
                skip_next = 1'b0;
            end
            else
            begin
                unique case (mode_reg)
                    stt_pkg::MODE_BLOCKCOM:
                    begin
                        if ((item.b == stt_pkg::CH_STAR) && (item.n1 == stt_pkg::CH_SLASH))
                        begin
                            mode_next = stt_pkg::MODE_IDLE;
                            skip_next = 1'b1;
                        end
                    end
                    stt_pkg::MODE_LINECOM:
                    begin
                        // The newline that ends the comment is ordinary whitespace.
                        if (item.b == stt_pkg::CH_NL)
                        begin
                            mode_next = stt_pkg::MODE_IDLE;
                            cnt_line  = 1'b1;
                            nl_next   = 1'b1;
                        end
                    end
                    stt_pkg::MODE_QUOTE:
                    begin
                        if (item.b == stt_pkg::CH_DQUOTE)
                        begin
                            mode_next = stt_pkg::MODE_IDLE;
                            len_next  = '0;
                        end
                        else if ((item.b == stt_pkg::CH_BSLASH)
                            && (item.n1 == stt_pkg::CH_DQUOTE))
                        begin
                            tok_v     = 1'b1;
                            tok_b     = stt_pkg::CH_DQUOTE;
                            tok_l     = (item.n2 == stt_pkg::CH_DQUOTE) || (item.n2 == 8'd0);
                            skip_next = 1'b1;
                        end
                        else
                        begin
                            cnt_line = (item.b == stt_pkg::CH_NL);
                            tok_v    = 1'b1;
                            tok_l    = (item.n1 == stt_pkg::CH_DQUOTE) || (item.n1 == 8'd0);
                        end
                    end
                    stt_pkg::MODE_NUMBER:
                    begin
                        num_v = 1'b1;
                    end
                    stt_pkg::MODE_WORD:
                    begin
                        cont  = stt_pkg::word_cont(item.n1);
                        tok_v = 1'b1;
                        tok_c = stt_pkg::CLS_WORD;
                        tok_l = !cont;
                        if (!cont)
                        begin
                            mode_next = stt_pkg::MODE_IDLE;
                        end
                    end
                    stt_pkg::MODE_OP2:
                    begin
                        put_v       = 1'b1;
                        put_r.tbyte = item.b;
                        put_r.cls   = stt_pkg::CLS_OPERATOR;
                        put_r.last  = 1'b1;
                        mode_next   = stt_pkg::MODE_IDLE;
                    end
                    stt_pkg::MODE_IDLE:
                    begin
                        if (item.b <= stt_pkg::CH_SPACE)
                        begin
                            if (item.b == stt_pkg::CH_NL)
                            begin
                                cnt_line = 1'b1;
                                nl_next  = 1'b1;
                            end
                        end
                        else
                        begin
                            marker   = nl_reg && !allow_line_breaks;
                            nl_next  = 1'b0;
                            len_base = '0;
                            len_next = '0;
                            exp_in   = 2'd0;
                            exp_next = 2'd0;
                            if ((item.b == stt_pkg::CH_SLASH) && (item.n1 == stt_pkg::CH_SLASH))
                            begin
                                mode_next = stt_pkg::MODE_LINECOM;
                                skip_next = 1'b1;
                            end
                            else if ((item.b == stt_pkg::CH_SLASH)
                                && (item.n1 == stt_pkg::CH_STAR))
                            begin
                                mode_next = stt_pkg::MODE_BLOCKCOM;
                                skip_next = 1'b1;
                            end
                            else if (item.b == stt_pkg::CH_DQUOTE)
                            begin
                                mode_next = stt_pkg::MODE_QUOTE;
                                // An empty string still yields one result.
                                if ((item.n1 == stt_pkg::CH_DQUOTE) || (item.n1 == 8'd0))
                                begin
                                    put_v       = 1'b1;
                                    put_r.cls   = stt_pkg::CLS_QUOTED;
                                    put_r.first = 1'b1;
                                    put_r.last  = 1'b1;
                                end
                            end
                            else if (stt_pkg::is_digit(item.b)
                                || ((item.b == stt_pkg::CH_MINUS) && stt_pkg::is_digit(item.n1))
                                || ((item.b == stt_pkg::CH_DOT) && stt_pkg::is_digit(item.n1))
                                || ((item.b == stt_pkg::CH_MINUS)
                                    && (item.n1 == stt_pkg::CH_DOT)
                                    && stt_pkg::is_digit(item.n2)))
                            begin
                                mode_next = stt_pkg::MODE_NUMBER;
                                num_v     = 1'b1;
                            end
                            else if (stt_pkg::word_start(item.b))
                            begin
                                cont      = stt_pkg::word_cont(item.n1);
                                mode_next = cont ? stt_pkg::MODE_WORD : stt_pkg::MODE_IDLE;
                                tok_v     = 1'b1;
                                tok_c     = stt_pkg::CLS_WORD;
                                tok_l     = !cont;
                            end
                            else if (stt_pkg::is_op_pair(item.b, item.n1))
                            begin
                                put_v       = 1'b1;
                                put_r.tbyte = item.b;
                                put_r.cls   = stt_pkg::CLS_OPERATOR;
                                put_r.first = 1'b1;
                                mode_next   = stt_pkg::MODE_OP2;
                            end
                            else
                            begin
                                put_v       = 1'b1;
                                put_r.tbyte = item.b;
                                put_r.cls   = stt_pkg::CLS_PUNCT;
                                put_r.first = 1'b1;
                                put_r.last  = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        mode_next = stt_pkg::MODE_IDLE;
                    end
                endcase

                if (num_v)
                begin
                    // The byte after an exponent marker or its sign is always taken.
                    if (exp_in == 2'd0)
                    begin
                        if ((item.b == stt_pkg::CH_LE) || (item.b == stt_pkg::CH_UE))
                        begin
                            exp_out  = 2'd1;
                            num_cont = (item.n1 != 8'd0);
                        end
                        else
                        begin
                            exp_out  = 2'd0;
                            num_cont = stt_pkg::is_digit(item.n1) || (item.n1 == stt_pkg::CH_DOT)
                                || (item.n1 == stt_pkg::CH_LE) || (item.n1 == stt_pkg::CH_UE);
                        end
                    end
                    else if ((exp_in == 2'd1)
                        && ((item.b == stt_pkg::CH_PLUS) || (item.b == stt_pkg::CH_MINUS)))
                    begin
                        exp_out  = 2'd2;
                        num_cont = (item.n1 != 8'd0);
                    end
                    else
                    begin
                        exp_out  = 2'd3;
                        num_cont = stt_pkg::is_digit(item.n1);
                    end
                    tok_v = 1'b1;
                    tok_c = stt_pkg::CLS_NUMBER;
                    tok_l = !num_cont;
                    if (num_cont)
                    begin
                        exp_next = exp_out;
                    end
                    else
                    begin
                        mode_next = stt_pkg::MODE_IDLE;
                        exp_next  = 2'd0;
                    end
                end
            end
        end

        lc_next = lc_reg;
        if (cnt_line && (lc_reg != '1))
        begin
            lc_next = lc_reg + 1'b1;
        end

        // Token byte emission with the length limit; an over-long token
        // closes with an empty last result.
        if (tok_v)
        begin
            if (len_base < stt_pkg::TOK_LEN_LIMIT)
            begin
                tres_v       = 1'b1;
                tres.tbyte   = tok_b;
                tres.cls     = tok_c;
                tres.first   = (len_base == '0);
                tres.last    = tok_l;
                len_next     = tok_l ? '0 : len_base + 1'b1;
            end
            else
            begin
                tres_v       = tok_l;
                tres.cls     = tok_c;
                tres.last    = 1'b1;
                len_next     = tok_l ? '0 : len_base;
            end
        end

        second_v      = put_v || tres_v;
        second        = put_v ? put_r : tres;
        second.line   = lc_next;
        mark_r        = '0;
        mark_r.cls    = stt_pkg::CLS_LINE_BREAK;
        mark_r.first  = 1'b1;
        mark_r.last   = 1'b1;
        mark_r.line   = lc_next;
        if (marker)
        begin
            r0    = mark_r;
            r1    = second;
            n_res = second_v ? 2'd2 : 2'd1;
        end
        else
        begin
            r0    = second;
            r1    = second;
            n_res = second_v ? 2'd1 : 2'd0;
        end

        q0_next  = q0_reg;
        q1_next  = q1_reg;
        occ_next = occ_reg;
        if (pop)
        begin
            q0_next  = r0;
            q1_next  = r1;
            occ_next = n_res;
        end
        else if (out_take)
        begin
            q0_next  = q1_reg;
            occ_next = occ_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= stt_pkg::MODE_IDLE;
            len_reg  <= '0;
            nl_reg   <= 1'b0;
            lc_reg   <= '0;
            exp_reg  <= 2'd0;
            skip_reg <= 1'b0;
            occ_reg  <= 2'd0;
        end
        else
        begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            nl_reg   <= nl_next;
            lc_reg   <= lc_next;
            exp_reg  <= exp_next;
            skip_reg <= skip_next;
            occ_reg  <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg != 2'd3)
        else $error("output buffer over-full");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && item.is_end) |=> ((mode_reg == stt_pkg::MODE_IDLE) && (len_reg == '0)
            && !skip_reg && !nl_reg && (occ_reg == 2'd1)))
        else $error("end of text did not return the lexer to idle");

endmodule

[hw/rtl/source_text_tokenizer_top.sv]
// Top level of the source text tokenizer: configuration register, front end,
// work queue and back end.
// Depends on stt_pkg, stt_front, stt_queue and stt_back.
//
// Usage: source bytes enter on the s_axis channel, one byte per transfer;
// byte 0 ends the text. Tokens leave on the m_axis channel, one token byte
// per transfer, tagged with class and first flag in tuser and with tlast on
// the last byte of each token or marker. An end-of-text marker follows the
// last token. allow_line_breaks is written over the APB port at address 0
// while the block is idle.
// Throughput: one byte per cycle while the queue has room and the receiver
// takes each result. A byte that yields two results (a line-break marker plus a
// token byte) holds the back end while its single output port sends both. At end
// of text the front end drains its two lookahead bytes and then the end command,
// holding s_axis_tready low after the byte 0 transfer until the end command.
// A byte's results become valid on m_axis after the transfer of the byte two
// places later: its work item enters the queue at that transfer, and the back end
// then pops it and loads its output register.
// Reset clears the lookahead, lexer state, line counter and register.
// When the receiver stalls, results wait in a two-entry output buffer and
// bytes collect in a four-entry queue before s_axis_tready drops.
module source_text_tokenizer_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // Source bytes
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] text_byte
    // Token bytes
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [stt_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,   // token_byte, line_count
    output logic [3:0]                        m_axis_tuser,   // token_class[2:0], token_first
    output logic                              m_axis_tlast    // token_last
);

    logic             allow_reg, allow_next;
    logic             cfg_write;
    logic             push;
    stt_pkg::work_t   push_item;
    logic             q_full;
    logic             pop;
    stt_pkg::work_t   pop_item;
    logic             q_empty;
    stt_pkg::result_t out_res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
        && (paddr[2] == stt_pkg::REG_ALLOW_LINE_BREAKS);
    assign allow_next = cfg_write ? pwdata[0] : allow_reg;
    assign prdata     = (paddr[2] == stt_pkg::REG_ALLOW_LINE_BREAKS)
        ? {31'd0, allow_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_reg <= 1'b0;
        end
        else
        begin
            allow_reg <= allow_next;
        end
    end

    stt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    stt_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    stt_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .allow_line_breaks (allow_reg),
        .q_empty           (q_empty),
        .item              (pop_item),
        .pop               (pop),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .out_res           (out_res)
    );

    assign m_axis_tdata = stt_pkg::OUT_DATA_BITS'({out_res.line, out_res.tbyte});
    assign m_axis_tuser = {out_res.first, out_res.cls};
    assign m_axis_tlast = out_res.last;

endmodule
